// ===== design/cfifo_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfifo_pkg - shared types and constants of the circular FIFO block
// Holds the operation and status codes, the beat types of both channels,
// the stored entry format and the ring pointer helpers.
// ---------------------------------------------------------------------------
package cfifo_pkg;

   localparam int DEPTH   = 64;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;
   localparam int OUT_N_W = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ENQ = 2'd0,
      FUNC_DEQ = 2'd1,
      FUNC_CLR = 2'd2
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // One request beat.
   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic signed [WORD_W-1:0] pop_value;
      logic [STAT_W-1:0]        status;
      logic [OUT_N_W-1:0]       fill_count;
      logic signed [WORD_W-1:0] content_sum;
      logic [OUT_N_W-1:0]       run_total;
   } rsp_type;

   // Stored word plus a mark that it differs from the word enqueued before it.
   typedef struct packed {
      logic                     diff;
      logic signed [WORD_W-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== design/circular_fifo_with_sum_and_runs_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circular_fifo_with_sum_and_runs_top - circular FIFO with sum and run count
// Queue of signed 32-bit words with per-operation status, running sum and
// count of runs of equal adjacent words.
// ---------------------------------------------------------------------------
// Each request beat carries one operation (enqueue, dequeue or clear) and
// yields exactly one response beat, in order. A beat is registered on entry,
// applied to the queue once the response register is free or draining and
// presented from the response register. One operation per cycle is
// sustained while the response side keeps taking beats. That rate rests on
// the combinational update of the pointers, running sum and run count: the
// two oldest words live in registers and the third is read ahead from the
// single read port of the store, so no operation waits on the RAM. The block
// takes requests straight out of reset; the store needs no clearing pass,
// since only words that were written and are still held are ever used.
module circular_fifo_with_sum_and_runs_top (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [cfifo_pkg::FUNC_W-1:0]                 req_func,
   input  logic signed [cfifo_pkg::WORD_W-1:0]          req_push_value,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic signed [cfifo_pkg::WORD_W-1:0]          rsp_pop_value,
   output logic [cfifo_pkg::STAT_W-1:0]                 rsp_status,
   output logic [cfifo_pkg::OUT_N_W-1:0]                rsp_fill_count,
   output logic signed [cfifo_pkg::WORD_W-1:0]          rsp_content_sum,
   output logic [cfifo_pkg::OUT_N_W-1:0]                rsp_run_total
);
   import cfifo_pkg::*;

   // Request register: holds one beat until it is applied.
   logic    s_valid_ff, s_valid_in;
   req_type s_req_ff;
   // Response register: holds one result until the consumer takes it.
   logic    o_valid_ff, o_valid_in;
   rsp_type o_rsp_ff;
   rsp_type core_rsp;
   logic    fire;
   logic    req_take;

   // Apply the held beat whenever the response register is free or draining.
   assign fire      = s_valid_ff && (!o_valid_ff || rsp_ready);
   assign req_ready = !s_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s_valid_in = s_valid_ff;
      if (req_take) begin
         s_valid_in = 1'b1;
      end else if (fire) begin
         s_valid_in = 1'b0;
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      if (fire) begin
         o_valid_in = 1'b1;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // Capture the incoming beat; hold the result until taken.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s_req_ff <= '{func: req_func, push_value: req_push_value};
      end
      if (fire) begin
         o_rsp_ff <= core_rsp;
      end
   end

   cfifo_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (s_req_ff),
      .rsp   (core_rsp)
   );

   assign rsp_valid       = o_valid_ff;
   assign rsp_pop_value   = o_rsp_ff.pop_value;
   assign rsp_status      = o_rsp_ff.status;
   assign rsp_fill_count  = o_rsp_ff.fill_count;
   assign rsp_content_sum = o_rsp_ff.content_sum;
   assign rsp_run_total   = o_rsp_ff.run_total;

   // A held request is never dropped: it either fires or stays.
   a_req_kept: assert property (@(posedge clock) disable iff (reset)
      (s_valid_ff && !fire) |=> s_valid_ff)
      else $error("held request beat lost");

   // A pending result is never overwritten before it is taken.
   a_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !rsp_ready) |-> !fire)
      else $error("result overwritten while stalled");

   // Every applied beat produces a result in the next cycle.
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> o_valid_ff)
      else $error("applied beat without result");

endmodule

// ===== design/cfifo_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfifo_ram - generic single write, single read RAM
// One write port, one read port with registered read data. A read of the
// address written in the same cycle returns the new data.
// ---------------------------------------------------------------------------
module cfifo_ram #(
   parameter int DATA_W = 8,
   parameter int WORDS  = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                      wr_data,
   input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                      rd_data
);

   logic [DATA_W-1:0] mem_ff [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Forward the write data on an address match.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cfifo_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfifo_core - ring store, pointers, running sum and run count
// Applies one operation per fire and forms its result. The two oldest
// entries sit in registers; the third is prefetched from the RAM.
// ---------------------------------------------------------------------------
module cfifo_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  cfifo_pkg::req_type req,
   output cfifo_pkg::rsp_type rsp
);
   import cfifo_pkg::*;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   logic signed [WORD_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]         run_ff, run_in;
   logic signed [WORD_W-1:0] last_ff, last_in;
   logic signed [WORD_W-1:0] front0_ff, front0_in;
   entry_type                front1_ff, front1_in;

   logic                     wr_en;
   entry_type                wr_entry;
   entry_type                third_entry;
   logic [PTR_W-1:0]         head_sel;
   logic [PTR_W-1:0]         rd_addr;
   logic                     diff;
   logic signed [WORD_W-1:0] pop_value;
   logic [STAT_W-1:0]        status;

   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      sum_in    = sum_ff;
      run_in    = run_ff;
      last_in   = last_ff;
      front0_in = front0_ff;
      front1_in = front1_ff;
      wr_en     = 1'b0;
      pop_value = '0;
      status    = STATUS_OK;
      diff      = (last_ff != req.push_value);
      wr_entry  = '{diff: diff, value: req.push_value};
      unique case (req.func)
         FUNC_ENQ: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               tail_in  = ptr_next(tail_ff);
               count_in = count_ff + 1'b1;
               sum_in   = sum_ff + req.push_value;
               last_in  = req.push_value;
               if (count_ff == '0) begin
                  run_in    = CNT_W'(1);
                  front0_in = req.push_value;
               end else begin
                  run_in = run_ff + CNT_W'(diff);
               end
               if (count_ff == CNT_W'(1)) begin
                  front1_in = wr_entry;
               end
            end
         end
         FUNC_DEQ: begin
            if (count_ff == '0) begin
               status    = STATUS_EMPTY;
               pop_value = '1;
            end else begin
               pop_value = front0_ff;
               head_in   = ptr_next(head_ff);
               count_in  = count_ff - 1'b1;
               sum_in    = sum_ff - front0_ff;
               front0_in = front1_ff.value;
               front1_in = third_entry;
               if (count_ff == CNT_W'(1)) begin
                  run_in = '0;
               end else if (front1_ff.diff) begin
                  run_in = run_ff - 1'b1;
               end
            end
         end
         FUNC_CLR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            sum_in   = '0;
            run_in   = '0;
         end
         default: begin
         end
      endcase
   end

   // Prefetch the entry two places past the head that holds after this edge.
   assign head_sel = fire ? head_in : head_ff;
   assign rd_addr  = ptr_next(ptr_next(head_sel));

   cfifo_ram #(
      .DATA_W (ENTRY_W),
      .WORDS  (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (fire && wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (third_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         sum_ff   <= '0;
         run_ff   <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         sum_ff   <= sum_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         last_ff   <= last_in;
         front0_ff <= front0_in;
         front1_ff <= front1_in;
      end
   end

   assign rsp = '{
      pop_value:   pop_value,
      status:      status,
      fill_count:  OUT_N_W'(count_in),
      content_sum: sum_in,
      run_total:   OUT_N_W'(run_in)
   };

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (run_ff == '0 && sum_ff == '0))
      else $error("empty queue with nonzero sum or run count");

   a_runs_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (run_ff != '0 && run_ff <= count_ff))
      else $error("run count out of range for held entries");

   a_tail_track: assert property (@(posedge clock) disable iff (reset)
      (fire && req.func == FUNC_ENQ && count_ff != CNT_W'(DEPTH))
      |=> (tail_ff != $past(tail_ff) || DEPTH == 1))
      else $error("tail did not advance on accepted enqueue");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - self-checking testbench for the circular FIFO with sum and run count
// Drives enqueue, dequeue, clear and unused-code beats through the request
// channel, mirrors the queue in a shadow model and checks every field of
// every response beat in order. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb;

   import cfifo_pkg::*;

   // The unused operation code: the block must treat it as a no-op.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1650;
   localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int HOLD_OFF     = 8;     // settling cycles once all beats are in

   typedef enum int {EP_FILL, EP_DRAIN, EP_MIX} episode_kind;
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style;

   // Shadow of the queue: predicts each response beat from the request beats
   // taken so far and checks the beats that come back against it.
   class fifo_mirror;
      logic [WORD_W-1:0] words [DEPTH];
      int                head;
      int                tail;
      int                held;
      int                runs;
      logic [WORD_W-1:0] total;
      rsp_type           awaited [$];
      int                mismatch_count;

      function new();
         head = 0;
         tail = 0;
         held = 0;
         runs = 0;
         total = '0;
         mismatch_count = 0;
      endfunction

      function void take_request(logic [FUNC_W-1:0] op, logic [WORD_W-1:0] word);
         rsp_type r;
         int      succ;
         r = '0;
         r.status = STATUS_OK;
         case (op)
            FUNC_ENQ: begin
               if (held >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  if (held == 0) begin
                     runs = 1;
                  end else if (words[(tail + DEPTH - 1) % DEPTH] != word) begin
                     runs++;
                  end
                  words[tail] = word;
                  tail = (tail + 1) % DEPTH;
                  held++;
                  total = total + word;
               end
            end
            FUNC_DEQ: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
                  r.pop_value = '1;
               end else begin
                  succ = (head + 1) % DEPTH;
                  r.pop_value = words[head];
                  if (held == 1) begin
                     runs = 0;
                  end else if (words[succ] != words[head]) begin
                     runs--;
                  end
                  total = total - words[head];
                  head = succ;
                  held--;
               end
            end
            FUNC_CLR: begin
               head = 0;
               tail = 0;
               held = 0;
               runs = 0;
               total = '0;
            end
            default: begin
            end
         endcase
         r.fill_count = OUT_N_W'(held);
         r.content_sum = total;
         r.run_total = OUT_N_W'(runs);
         awaited.push_back(r);
      endfunction

      function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, field, want, got);
            mismatch_count++;
         end
      endfunction

      function void match_response(logic [WORD_W-1:0] pop, logic [STAT_W-1:0] st,
                                   logic [OUT_N_W-1:0] fill, logic [WORD_W-1:0] sum,
                                   logic [OUT_N_W-1:0] run_n);
         rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response beat with nothing outstanding, expected none, actual pop 0x%08h status %0d",
                     $time, pop, st);
            mismatch_count++;
            return;
         end
         want = awaited.pop_front();
         compare("pop_value", want.pop_value, pop);
         compare("status", WORD_W'(want.status), WORD_W'(st));
         compare("fill_count", WORD_W'(want.fill_count), WORD_W'(fill));
         compare("content_sum", want.content_sum, sum);
         compare("run_total", WORD_W'(want.run_total), WORD_W'(run_n));
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = FUNC_ENQ;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_pop_value;
   logic [STAT_W-1:0]        rsp_status;
   logic [OUT_N_W-1:0]       rsp_fill_count;
   logic signed [WORD_W-1:0] rsp_content_sum;
   logic [OUT_N_W-1:0]       rsp_run_total;

   fifo_mirror        book = new();
   int                burst_left = 0;
   logic [WORD_W-1:0] last_word = '0;
   rx_style           rx_mode = RX_OPEN;
   int                rx_left = 0;
   int                rx_phase = 0;

   circular_fifo_with_sum_and_runs_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_status      (rsp_status),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_content_sum (rsp_content_sum),
      .rsp_run_total   (rsp_run_total)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Monitor both channels at the edge. Note the request first, so that the
   // shadow is never behind the beat it is about to check.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            book.take_request(req_func, req_push_value);
         end
         if (rsp_valid && rsp_ready) begin
            book.match_response(rsp_pop_value, rsp_status, rsp_fill_count,
                                rsp_content_sum, rsp_run_total);
         end
      end
   end

   // Receiver: switch between stall styles at random intervals. The sparse
   // style raises ready only on a periodic phase of a running counter.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_style'($urandom_range(0, 3));
         rx_left = $urandom_range(50, 300);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_SPARSE: rsp_ready <= (rx_phase % 5 == 0);
         default:   rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Present one request beat and hold it until it is taken. Between bursts,
   // drop valid for a random gap and scramble the idle payload.
   task automatic send_beat(input logic [FUNC_W-1:0] op, input logic [WORD_W-1:0] word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_func <= FUNC_W'($urandom_range(0, 3));
            req_push_value <= $urandom;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 80 : 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= op;
      req_push_value <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold the sender until every outstanding response beat has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.awaited.size() != 0);
   endtask

   // Favour repeats of the previous word and a few small values, so that runs
   // of equal neighbours form often; mix in the extremes and full-range words.
   function automatic logic [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         return last_word;
      end else if (r < 55) begin
         last_word = WORD_W'($urandom_range(0, 3));
      end else if (r < 62) begin
         case ($urandom_range(0, 3))
            0:       last_word = 32'h7fff_ffff;
            1:       last_word = 32'h8000_0000;
            2:       last_word = 32'hffff_ffff;
            default: last_word = '0;
         endcase
      end else begin
         last_word = $urandom;
      end
      return last_word;
   endfunction

   // Fill episodes push the queue to full and beyond, drain episodes empty
   // it and keep popping, mixed ones wander. Clears and unused codes are rare.
   function automatic logic [FUNC_W-1:0] pick_op(episode_kind kind);
      int r;
      int enq_cut;
      int deq_cut;
      r = $urandom_range(0, 99);
      case (kind)
         EP_FILL:  begin enq_cut = 88; deq_cut = 97; end
         EP_DRAIN: begin enq_cut = 12; deq_cut = 97; end
         default:  begin enq_cut = 45; deq_cut = 90; end
      endcase
      if (r < enq_cut) return FUNC_ENQ;
      if (r < deq_cut) return FUNC_DEQ;
      if (r < deq_cut + 2) return FUNC_UNUSED;
      return FUNC_CLR;
   endfunction

   initial begin : stimulus
      int               sent;
      int               span;
      int               n;
      episode_kind      kind;
      logic [FUNC_W-1:0] op;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-queue cases, extremes, wrap of the sum, equal and
      // unequal neighbours, clear with entries held, last entry leaving.
      send_beat(FUNC_DEQ, 32'h0000_0000);
      send_beat(FUNC_UNUSED, 32'hdead_beef);
      send_beat(FUNC_CLR, 32'hffff_ffff);
      send_beat(FUNC_ENQ, 32'h7fff_ffff);
      send_beat(FUNC_ENQ, 32'h7fff_ffff);
      send_beat(FUNC_ENQ, 32'h8000_0000);
      send_beat(FUNC_ENQ, 32'h8000_0000);
      send_beat(FUNC_ENQ, 32'hffff_ffff);
      send_beat(FUNC_ENQ, 32'h0000_0000);
      send_beat(FUNC_ENQ, 32'h0000_0000);
      send_beat(FUNC_UNUSED, 32'h5555_aaaa);
      send_beat(FUNC_DEQ, 32'hffff_ffff);
      send_beat(FUNC_DEQ, 32'h0000_0000);
      send_beat(FUNC_DEQ, 32'h0000_0000);
      send_beat(FUNC_CLR, 32'h0000_0000);
      send_beat(FUNC_DEQ, 32'h0000_0000);
      send_beat(FUNC_ENQ, 32'h0000_0005);
      send_beat(FUNC_DEQ, 32'h0000_0000);
      send_beat(FUNC_ENQ, 32'h0000_0005);
      send_beat(FUNC_ENQ, 32'h0000_0005);
      send_beat(FUNC_ENQ, 32'h0000_0006);
      send_beat(FUNC_DEQ, 32'h0000_0000);
      send_beat(FUNC_DEQ, 32'h0000_0000);
      send_beat(FUNC_DEQ, 32'h0000_0000);
      send_beat(FUNC_DEQ, 32'h0000_0000);

      // Let the pipeline empty completely before the random part.
      settle();

      // Random: episodes of biased operations. Start with a long fill so the
      // queue reaches full early; unused codes do not count towards the total.
      sent = 0;
      kind = EP_FILL;
      span = 150;
      while (sent < RANDOM_ITEMS) begin
         for (n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
            op = pick_op(kind);
            send_beat(op, (op == FUNC_ENQ) ? pick_word() : WORD_W'($urandom));
            if (op != FUNC_UNUSED) begin
               sent++;
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            settle();
         end
         kind = episode_kind'($urandom_range(0, 2));
         span = (kind == EP_MIX) ? $urandom_range(20, 80) : $urandom_range(60, 150);
      end

      // Wait for the last response beats, then hold off so that any stray beat
      // is caught before the verdict.
      req_valid <= 1'b0;
      do @(posedge clock); while (book.awaited.size() != 0);
      repeat (HOLD_OFF) @(posedge clock);

      if (book.mismatch_count == 0 && book.awaited.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== circular_fifo_with_sum_and_runs_top.f =====
design/cfifo_pkg.sv
design/cfifo_ram.sv
design/cfifo_core.sv
design/circular_fifo_with_sum_and_runs_top.sv
dv/tb.sv
